// ===== rtl/u8d_pkg.sv =====
// Shared definitions for the UTF-8 stream decoder: byte class codes,
// range limits and the queue entry type.
// No dependencies.
package u8d_pkg;

  // Default number of entries in the queue between the front and the back end.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Byte class codes produced by the front end.
  localparam logic [2:0] CLS_ASCII = 3'd0;
  localparam logic [2:0] CLS_LEAD2 = 3'd1;
  localparam logic [2:0] CLS_LEAD3 = 3'd2;
  localparam logic [2:0] CLS_LEAD4 = 3'd3;
  localparam logic [2:0] CLS_CONT  = 3'd4;
  localparam logic [2:0] CLS_BAD   = 3'd5;

  // Lead byte ranges.
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Continuation byte marker: top two bits are 10.
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  // Limits on the first continuation byte after special lead bytes.
  localparam logic [7:0] LEAD_E0   = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD_F0   = 8'hF0;
  localparam logic [7:0] LEAD_F4   = 8'hF4;
  localparam logic [7:0] E0_MIN    = 8'hA0;
  localparam logic [7:0] ED_MAX    = 8'h9F;
  localparam logic [7:0] F0_MIN    = 8'h90;
  localparam logic [7:0] F4_MAX    = 8'h8F;

  // Largest scalar value and the surrogate range.
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] cls;
  } u8d_item_t;

endpackage

// ===== rtl/u8d_front.sv =====
// Front end of the UTF-8 stream decoder: takes input transfers and
// classifies each byte. Depends on u8d_pkg.
module u8d_front
  import u8d_pkg::*;
(
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       q_push,
  output u8d_item_t  q_item
);

  logic [2:0] cls;

  // Sort the byte into ASCII, lead byte of a given length, continuation or invalid.
  always_comb begin
    if (!in_data_byte[7]) begin
      cls = CLS_ASCII;
    end else if ((in_data_byte & CONT_MASK) == CONT_TAG) begin
      cls = CLS_CONT;
    end else if (in_data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
      cls = CLS_LEAD2;
    end else if (in_data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
      cls = CLS_LEAD3;
    end else if (in_data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
  end

  // A transfer happens whenever a byte is offered and the queue has room.
  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  assign q_item.data  = in_data_byte;
  assign q_item.last  = in_last_byte;
  assign q_item.cls   = cls;

endmodule

// ===== rtl/u8d_queue.sv =====
// Short first-in first-out queue of classified bytes between the front
// and the back end. Depends on u8d_pkg.
module u8d_queue
  import u8d_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  u8d_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output u8d_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u8d_item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  // Pointer and fill count updates, with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/u8d_back.sv =====
// Back end of the UTF-8 stream decoder: runs the sequence state, assembles
// code points and holds the result register. Depends on u8d_pkg.
module u8d_back
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  u8d_item_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_codepoint,
  output logic        out_has_codepoint,
  output logic        out_text_done,
  output logic        out_text_valid
);

  logic [1:0]  owed_r, owed_nxt;
  logic [7:0]  lead_r, lead_nxt;
  logic        second_r, second_nxt;
  logic [20:0] asm_r, asm_nxt;
  logic        failed_r, failed_nxt;

  logic        out_valid_r;
  logic [20:0] cp_r;
  logic        has_cp_r, done_r, text_ok_r;

  logic        cp_hit;
  logic [20:0] cp_val;
  logic        range_bad;
  logic        emit;
  logic [7:0]  b;

  assign b = q_head.data;

  // Take the next byte when the result register is free or being drained.
  assign q_pop = q_not_empty && (!out_valid_r || !out_stall);

  // Overlong, surrogate and too-large checks on the first continuation byte.
  assign range_bad = ((lead_r == LEAD_E0) && (b < E0_MIN)) ||
                     ((lead_r == LEAD_ED) && (b > ED_MAX)) ||
                     ((lead_r == LEAD_F0) && (b < F0_MIN)) ||
                     ((lead_r == LEAD_F4) && (b > F4_MAX));

  // Sequence state update for one byte.
  always_comb begin
    owed_nxt   = owed_r;
    lead_nxt   = lead_r;
    second_nxt = second_r;
    asm_nxt    = asm_r;
    failed_nxt = failed_r;
    cp_hit     = 1'b0;
    cp_val     = '0;
    if (!failed_r) begin
      if (owed_r == 2'd0) begin
        case (q_head.cls)
          CLS_ASCII: begin
            cp_hit = 1'b1;
            cp_val = {13'd0, b};
          end
          CLS_LEAD2: begin
            owed_nxt   = 2'd1;
            asm_nxt    = {16'd0, b[4:0]};
            lead_nxt   = b;
            second_nxt = 1'b1;
          end
          CLS_LEAD3: begin
            owed_nxt   = 2'd2;
            asm_nxt    = {17'd0, b[3:0]};
            lead_nxt   = b;
            second_nxt = 1'b1;
          end
          CLS_LEAD4: begin
            owed_nxt   = 2'd3;
            asm_nxt    = {18'd0, b[2:0]};
            lead_nxt   = b;
            second_nxt = 1'b1;
          end
          default: begin
            failed_nxt = 1'b1;
          end
        endcase
      end else if ((q_head.cls != CLS_CONT) || (second_r && range_bad)) begin
        failed_nxt = 1'b1;
        owed_nxt   = 2'd0;
        second_nxt = 1'b0;
      end else begin
        second_nxt = 1'b0;
        asm_nxt    = {asm_r[14:0], b[5:0]};
        owed_nxt   = owed_r - 2'd1;
        if (owed_r == 2'd1) begin
          cp_hit = 1'b1;
          cp_val = {asm_r[14:0], b[5:0]};
        end
      end
    end
    // A text that ends with bytes still owed is truncated.
    if (q_head.last) begin
      if (owed_nxt != 2'd0) begin
        failed_nxt = 1'b1;
      end
    end
  end

  assign emit = cp_hit || q_head.last;

  // Sequence state registers; the last byte of a text clears them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r   <= '0;
      lead_r   <= '0;
      second_r <= 1'b0;
      asm_r    <= '0;
      failed_r <= 1'b0;
    end else if (q_pop) begin
      if (q_head.last) begin
        owed_r   <= '0;
        lead_r   <= '0;
        second_r <= 1'b0;
        asm_r    <= '0;
        failed_r <= 1'b0;
      end else begin
        owed_r   <= owed_nxt;
        lead_r   <= lead_nxt;
        second_r <= second_nxt;
        asm_r    <= asm_nxt;
        failed_r <= failed_nxt;
      end
    end
  end

  // Result valid flag: loaded on each consumed byte, dropped after a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cp_r      <= cp_val;
      has_cp_r  <= cp_hit;
      done_r    <= q_head.last;
      text_ok_r <= q_head.last && !failed_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_codepoint     = cp_r;
  assign out_has_codepoint = has_cp_r;
  assign out_text_done     = done_r;
  assign out_text_valid    = text_ok_r;

endmodule

// ===== rtl/utf8_stream_decoder.sv =====
// Top level of the strict UTF-8 stream decoder and validator.
// Depends on u8d_pkg, u8d_front, u8d_queue and u8d_back.

// The decoder takes one byte per clock and sustains one byte per cycle in
// both directions when the result side does not stall. A byte enters a
// queue of QUEUE_DEPTH entries at the edge where it is transferred. Its
// result, if any, is loaded into the output register when the back end
// takes the byte from the head of the queue. A result is produced when a
// code point completes and always on the byte flagged as last, which
// carries the verdict for the whole text. After an error no code points
// are produced until the end of the text. The input stalls only when the
// queue is full.
module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_codepoint,
  output logic        out_has_codepoint,
  output logic        out_text_done,
  output logic        out_text_valid
);

  logic      q_push, q_full, q_pop, q_not_empty;
  u8d_item_t q_in, q_head;

  // Byte classification and input transfer.
  u8d_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_in)
  );

  // Decoupling queue.
  u8d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head)
  );

  // Sequence decoding and result register.
  u8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_not_empty       (q_not_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_codepoint     (out_codepoint),
    .out_has_codepoint (out_has_codepoint),
    .out_text_done     (out_text_done),
    .out_text_valid    (out_text_valid)
  );

endmodule

// ===== rtl/u8d_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Depends on u8d_pkg and utf8_stream_decoder.
module u8d_checker
  import u8d_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [20:0] out_codepoint,
  input logic        out_has_codepoint,
  input logic        out_text_done,
  input logic        out_text_valid
);

  // A stalled input transfer keeps its valid and payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("input changed while stalled");

  // A stalled result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_codepoint) &&
      $stable(out_has_codepoint) && $stable(out_text_done) && $stable(out_text_valid))
    else $error("result changed while stalled");

  // A result without a code point carries a zero code point.
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_codepoint |-> out_codepoint == '0)
    else $error("nonzero code point without has_codepoint");

  // Only the end of a text may produce a result without a code point.
  a_mid_has_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_text_done |-> out_has_codepoint && !out_text_valid)
    else $error("mid-text result without code point or with verdict");

  // Every code point given out is a Unicode scalar value.
  a_cp_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_codepoint |->
      (out_codepoint <= CP_MAX) && ((out_codepoint < SURR_LO) || (out_codepoint > SURR_HI)))
    else $error("code point outside the scalar range");

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (.*);
